/* sv/inverter_enable_sequencer_macros.svh */
// Assertion helpers shared by the sequencer RTL.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef INVERTER_ENABLE_SEQUENCER_MACROS_SVH
`define INVERTER_ENABLE_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define IES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("inverter enable sequencer: same-cycle check failed");

// Next-cycle implication.
`define IES_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("inverter enable sequencer: next-cycle check failed");

`endif

/* sv/ies_pkg.sv */
package ies_pkg;

    // Motors that a feedback frame can address and that have a mask bit.
    localparam int PORT_MOTORS = 4;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_START    = 2'd1,
        OP_FEEDBACK = 2'd2,
        OP_STOP     = 2'd3
    } t_op;

    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_POS_LIM  = 2'd1;
    localparam logic [1:0] REG_NEG_LIM  = 2'd2;
    localparam logic [1:0] REG_CFG_MASK = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
    localparam logic [3:0]  CFG_MASK_RESET = 4'hF;

    typedef enum logic [10:0] {
        S_DISABLED     = 11'b000_0000_0001,
        S_WAIT_READY   = 11'b000_0000_0010,
        S_SET_DC       = 11'b000_0000_0100,
        S_WAIT_DC      = 11'b000_0000_1000,
        S_ENABLE       = 11'b000_0001_0000,
        S_WAIT_INV     = 11'b000_0010_0000,
        S_RUNNING      = 11'b000_0100_0000,
        S_DISABLE      = 11'b000_1000_0000,
        S_WAIT_INV_OFF = 11'b001_0000_0000,
        S_SET_DC_OFF   = 11'b010_0000_0000,
        S_WAIT_DC_OFF  = 11'b100_0000_0000
    } t_seq_state;

    typedef struct packed {
        t_op                operation;
        logic [1:0]         motor_index;
        logic               ready_fb;
        logic               dc_ack_fb;
        logic               inv_ack_fb;
        logic signed [15:0] torque_target;
    } t_in_item;

    typedef struct packed {
        logic               request_valid;
        logic [1:0]         request_motor;
        logic               dc_on_req;
        logic               drv_on_req;
        logic               inv_on_req;
        logic signed [15:0] torque_command;
        logic signed [15:0] positive_limit_out;
        logic signed [15:0] negative_limit_out;
        logic [3:0]         sequence_state;
        logic [3:0]         comm_fault_mask;
        logic               controller_running;
    } t_out_item;

    // Request frame contents held per motor.
    typedef struct packed {
        logic               dc;
        logic               drv;
        logic               inv;
        logic signed [15:0] torque;
        logic signed [15:0] pos_lim;
        logic signed [15:0] neg_lim;
    } t_request;

    // Event broadcast to every motor; the flags are already qualified by the transfer.
    typedef struct packed {
        logic               tick;
        logic               start;
        logic               stop;
        logic               feedback;
        logic               sys_ready;
        logic               dc_ack;
        logic               inv_ack;
        logic signed [15:0] setpoint;
        logic signed [15:0] pos_lim;
        logic signed [15:0] neg_lim;
    } t_motor_cmd;

    function automatic logic [3:0] f_state_code(t_seq_state s);
        logic [3:0] code;
        code = 4'd0;
        unique case (s)
            S_DISABLED:     code = 4'd0;
            S_WAIT_READY:   code = 4'd1;
            S_SET_DC:       code = 4'd2;
            S_WAIT_DC:      code = 4'd3;
            S_ENABLE:       code = 4'd4;
            S_WAIT_INV:     code = 4'd5;
            S_RUNNING:      code = 4'd6;
            S_DISABLE:      code = 4'd7;
            S_WAIT_INV_OFF: code = 4'd8;
            S_SET_DC_OFF:   code = 4'd9;
            S_WAIT_DC_OFF:  code = 4'd10;
            default:        code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

/* sv/inverter_enable_sequencer.sv */
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_ready    i_in_data (t_in_item)
// out      out  o_out_valid / i_out_ready  o_out_data (t_out_item)
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle is sustained while the output is taken. An item sits in the input
// register after its transfer and is processed into the result register once that register
// is free or its result is taken. The per-motor state machines and the age compare against
// the timeout sit between those two registers.
// Synchronous reset disables all motors, clears ages and faults and loads register defaults.
// A stalled output holds the result register; input ready drops only while both
// registers are full and the result is not taken. Configuration writes are registered.
`include "inverter_enable_sequencer_macros.svh"

module inverter_enable_sequencer
    import ies_pkg::*;
#(
    parameter int MOTOR_COUNT = 4,
    parameter int AGE_WIDTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic               r_in_valid, n_in_valid;
    t_in_item           r_in;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic               r_active, n_active;
    logic [15:0]        r_timeout;
    logic signed [15:0] r_pos_lim;
    logic signed [15:0] r_neg_lim;
    logic [3:0]         r_cfg_mask;

    logic       advance;
    logic       in_xfer;
    logic       fb_ok;
    t_motor_cmd cmd;

    t_seq_state             w_state [MOTOR_COUNT];
    t_request               w_req   [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] w_fault;
    logic [MOTOR_COUNT-1:0] w_sup;

    t_seq_state p_state [PORT_MOTORS];
    t_request   p_req   [PORT_MOTORS];
    logic       p_sup   [PORT_MOTORS];
    logic [3:0] fault_mask;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign fb_ok = (r_in.operation == OP_FEEDBACK) && (int'(r_in.motor_index) < MOTOR_COUNT);

    always_comb begin
        cmd           = '0;
        cmd.tick      = advance && (r_in.operation == OP_TICK);
        cmd.start     = advance && (r_in.operation == OP_START) && !r_active;
        cmd.stop      = advance && (r_in.operation == OP_STOP);
        cmd.feedback  = advance && fb_ok;
        cmd.sys_ready = r_in.ready_fb;
        cmd.dc_ack    = r_in.dc_ack_fb;
        cmd.inv_ack   = r_in.inv_ack_fb;
        cmd.setpoint  = r_in.torque_target;
        cmd.pos_lim   = r_pos_lim;
        cmd.neg_lim   = r_neg_lim;
    end

    for (genvar j = 0; j < MOTOR_COUNT; j++) begin : g_motor
        if (j < PORT_MOTORS) begin : g_sup
            assign w_sup[j] = r_cfg_mask[j];
        end else begin : g_nosup
            assign w_sup[j] = 1'b0;
        end

        ies_motor #(
            .AGE_WIDTH(AGE_WIDTH)
        ) u_motor (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_sel        (int'(r_in.motor_index) == j),
            .i_supervised (w_sup[j]),
            .i_timeout    (r_timeout),
            .o_state      (w_state[j]),
            .o_req        (w_req[j]),
            .o_fault      (w_fault[j])
        );
    end

    // Addressable view of the motors; slots above the motor count read as idle.
    for (genvar k = 0; k < PORT_MOTORS; k++) begin : g_port
        if (k < MOTOR_COUNT) begin : g_live
            assign p_state[k]    = w_state[k];
            assign p_req[k]      = w_req[k];
            assign p_sup[k]      = w_sup[k];
            assign fault_mask[k] = w_fault[k];
        end else begin : g_empty
            assign p_state[k]    = S_DISABLED;
            assign p_req[k]      = '0;
            assign p_sup[k]      = 1'b0;
            assign fault_mask[k] = 1'b0;
        end
    end

    always_comb begin
        n_active = r_active;
        if (cmd.start) begin
            n_active = 1'b1;
        end else if (cmd.stop) begin
            n_active = 1'b0;
        end
    end

    always_comb begin
        n_out                    = '0;
        n_out.comm_fault_mask    = fault_mask;
        n_out.controller_running = n_active;
        if (fb_ok) begin
            n_out.request_motor  = r_in.motor_index;
            n_out.sequence_state = f_state_code(p_state[r_in.motor_index]);
            if (p_sup[r_in.motor_index]) begin
                n_out.request_valid      = 1'b1;
                n_out.dc_on_req          = p_req[r_in.motor_index].dc;
                n_out.drv_on_req         = p_req[r_in.motor_index].drv;
                n_out.inv_on_req         = p_req[r_in.motor_index].inv;
                n_out.torque_command     = p_req[r_in.motor_index].torque;
                n_out.positive_limit_out = p_req[r_in.motor_index].pos_lim;
                n_out.negative_limit_out = p_req[r_in.motor_index].neg_lim;
            end
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_active    <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_pos_lim  <= '0;
            r_neg_lim  <= '0;
            r_cfg_mask <= CFG_MASK_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                REG_POS_LIM:  r_pos_lim  <= signed'(i_cfg_data);
                REG_NEG_LIM:  r_neg_lim  <= signed'(i_cfg_data);
                REG_CFG_MASK: r_cfg_mask <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Driver and inverter enables are always raised and dropped together.
    `IES_ASSERT_IMP(a_drv_inv_pair, r_out_valid, r_out.drv_on_req == r_out.inv_on_req)
    // The inverter is never requested on without the DC link.
    `IES_ASSERT_IMP(a_inv_needs_dc, r_out_valid && r_out.inv_on_req, r_out.dc_on_req)
    // A stop reports the controller as no longer running.
    `IES_ASSERT_NXT(a_stop_clears_run, advance && (r_in.operation == OP_STOP),
                    r_out_valid && !r_out.controller_running)
    // An item waiting in the input register is neither lost nor overwritten.
    `IES_ASSERT_NXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in))

endmodule

/* sv/ies_motor.sv */
module ies_motor
    import ies_pkg::*;
#(
    parameter int AGE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_motor_cmd  i_cmd,
    input  logic        i_sel,
    input  logic        i_supervised,
    input  logic [15:0] i_timeout,
    output t_seq_state  o_state,
    output t_request    o_req,
    output logic        o_fault
);

    localparam int CMP_W = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    t_seq_state           r_state, n_state;
    t_request             r_req, n_req;
    logic [AGE_WIDTH-1:0] r_age, n_age;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_age   = r_age;
        if (i_cmd.tick) begin
            if (r_age != AGE_MAX) begin
                n_age = r_age + 1'b1;
            end
        end else if (i_cmd.start) begin
            n_state = S_WAIT_READY;
        end else if (i_cmd.stop) begin
            if (r_state == S_WAIT_READY || r_state == S_SET_DC || r_state == S_WAIT_DC ||
                r_state == S_ENABLE || r_state == S_WAIT_INV || r_state == S_RUNNING) begin
                n_state = S_DISABLE;
            end
        end else if (i_cmd.feedback && i_sel) begin
            n_age = '0;
            if (i_supervised) begin
                unique case (r_state)
                    S_DISABLED: begin
                    end
                    S_WAIT_READY: begin
                        if (i_cmd.sys_ready) n_state = S_SET_DC;
                    end
                    S_SET_DC: begin
                        n_req.dc = 1'b1;
                        n_state  = S_WAIT_DC;
                    end
                    S_WAIT_DC: begin
                        if (i_cmd.dc_ack) n_state = S_ENABLE;
                    end
                    S_ENABLE: begin
                        n_req.torque  = '0;
                        n_req.pos_lim = '0;
                        n_req.neg_lim = '0;
                        n_req.drv     = 1'b1;
                        n_req.inv     = 1'b1;
                        n_state       = S_WAIT_INV;
                    end
                    S_WAIT_INV: begin
                        if (i_cmd.inv_ack) n_state = S_RUNNING;
                    end
                    S_RUNNING: begin
                        n_req.torque  = i_cmd.setpoint;
                        n_req.pos_lim = i_cmd.pos_lim;
                        n_req.neg_lim = i_cmd.neg_lim;
                    end
                    S_DISABLE: begin
                        n_req.torque  = '0;
                        n_req.pos_lim = '0;
                        n_req.neg_lim = '0;
                        n_req.drv     = 1'b0;
                        n_req.inv     = 1'b0;
                        n_state       = S_WAIT_INV_OFF;
                    end
                    S_WAIT_INV_OFF: begin
                        if (!i_cmd.inv_ack) n_state = S_SET_DC_OFF;
                    end
                    S_SET_DC_OFF: begin
                        n_req.dc = 1'b0;
                        n_state  = S_WAIT_DC_OFF;
                    end
                    S_WAIT_DC_OFF: begin
                        if (!i_cmd.dc_ack) n_state = S_DISABLED;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DISABLED;
            r_req   <= '0;
            r_age   <= '0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_age   <= n_age;
        end
    end

    // The result reports the motor as it stands after this event.
    assign o_state = n_state;
    assign o_req   = n_req;
    assign o_fault = i_supervised && (CMP_W'(n_age) > CMP_W'(i_timeout));

endmodule
